@@ sv/dq_pkg.sv @@
package dq_pkg;

  // Operation codes carried by each transaction
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_QUERY      = 3'd4;

  localparam int unsigned LIMIT_W = 5;
  localparam int unsigned WORD_W  = 32;

  localparam logic [LIMIT_W-1:0] DEPTH_LIMIT_RESET = 5'd16;
  localparam logic [WORD_W-1:0]  EMPTY_MARK        = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [WORD_W-1:0] push_value;
  } deq_in_t;

  typedef struct packed {
    logic                     success;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
  } deq_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic exec;   // apply the accepted operation
    logic rd_en;  // fetch front and rear words
  } dq_cmd_t;

endpackage

@@ sv/dq_ctrl.sv @@
module dq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output dq_pkg::dq_cmd_t cmd
);
  import dq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  // Only the read cycle blocks a new transaction
  assign busy   = (state == ST_READ);
  assign accept = start && !busy;

  assign cmd.exec  = accept;
  assign cmd.rd_en = (state == ST_READ);
  assign done      = (state == ST_RESP);

  // Advance the sequence: execute, read, respond
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_READ;
      ST_READ: state_next = ST_RESP;
      ST_RESP: state_next = accept ? ST_READ : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/dq_datapath.sv @@
module dq_datapath #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dq_pkg::dq_cmd_t              cmd,
  input  dq_pkg::deq_in_t              in_item,
  input  logic                         cfg_we,
  input  logic [dq_pkg::LIMIT_W-1:0]   cfg_data,
  output dq_pkg::deq_out_t             result
);
  import dq_pkg::*;

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
  localparam logic [SUM_W-1:0] MAX_SUM  = SUM_W'(MAX_ENTRIES);
  localparam logic [LIM_W-1:0] MAX_LIM  = LIM_W'(MAX_ENTRIES);

  logic [WORD_W-1:0]  mem [MAX_ENTRIES];

  logic [LIMIT_W-1:0] depth_limit;
  logic [IDX_W-1:0]   front_index;
  logic [IDX_W-1:0]   front_index_next;
  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   entry_count_next;
  logic               success;
  logic               success_next;
  logic [WORD_W-1:0]  rd_front;
  logic [WORD_W-1:0]  rd_rear;

  logic [CNT_W-1:0]   lim;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rear_addr;
  logic               is_empty;

  // Fold a sum below twice the capacity back into the ring
  function automatic logic [IDX_W-1:0] wrap_sum(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= MAX_SUM) ? (s - MAX_SUM) : s;
    return r[IDX_W-1:0];
  endfunction

  // Clamp the configured limit to the capacity
  always_comb begin
    logic [LIM_W-1:0] dl;
    dl  = LIM_W'(depth_limit);
    lim = (dl > MAX_LIM) ? CNT_W'(MAX_LIM) : CNT_W'(dl);
  end

  // Decide the operation and the next pointers
  always_comb begin
    front_index_next = front_index;
    entry_count_next = entry_count;
    success_next     = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = front_index;
    unique case (in_item.opcode)
      OP_PUSH_FRONT: begin
        if (entry_count < lim) begin
          front_index_next = (front_index == '0) ? LAST_IDX : front_index - 1'b1;
          wr_addr          = front_index_next;
          wr_en            = 1'b1;
          entry_count_next = entry_count + 1'b1;
          success_next     = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (entry_count < lim) begin
          wr_addr          = wrap_sum(SUM_W'(front_index) + SUM_W'(entry_count));
          wr_en            = 1'b1;
          entry_count_next = entry_count + 1'b1;
          success_next     = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (entry_count != '0) begin
          front_index_next = wrap_sum(SUM_W'(front_index) + SUM_W'(1));
          entry_count_next = entry_count - 1'b1;
          success_next     = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (entry_count != '0) begin
          entry_count_next = entry_count - 1'b1;
          success_next     = 1'b1;
        end
      end
      default: begin
        // query and unused codes leave the state alone
      end
    endcase
  end

  // Update the limit register and the ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= DEPTH_LIMIT_RESET;
      front_index <= '0;
      entry_count <= '0;
      success     <= 1'b0;
    end else begin
      if (cfg_we) begin
        depth_limit <= cfg_data;
      end
      if (cmd.exec) begin
        front_index <= front_index_next;
        entry_count <= entry_count_next;
        success     <= success_next;
      end
    end
  end

  // Rear position of the stored words
  assign rear_addr = (entry_count == '0) ? front_index
                   : wrap_sum(SUM_W'(front_index) + SUM_W'(entry_count) - SUM_W'(1));

  // Entry store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= in_item.push_value;
    end
    if (cmd.rd_en) begin
      rd_front <= mem[front_index];
      rd_rear  <= mem[rear_addr];
    end
  end

  // Form the response
  assign is_empty           = (entry_count == '0);
  assign result.success     = success;
  assign result.front_value = is_empty ? EMPTY_MARK : rd_front;
  assign result.rear_value  = is_empty ? EMPTY_MARK : rd_rear;
  assign result.is_empty    = is_empty;
  assign result.is_full     = (entry_count == lim);

endmodule

@@ sv/bounded_double_ended_queue.sv @@
// Bounded double-ended queue of signed 32-bit words in a ring of MAX_ENTRIES
// entries. A transaction is taken when start is high and busy is low; its
// result appears two cycles later for exactly one cycle with done high, and
// the receiver cannot hold it off, so it must capture the result in that
// cycle. One transaction every two cycles is sustained: the second cycle is
// the registered read of the front and rear words from the entry store, and
// a new transaction may be taken in the same cycle its predecessor's result
// is shown. The depth limit register (reset 16, clamped to MAX_ENTRIES) is
// written through cfg_we and cfg_data and should change only while no
// transaction is in flight.
module bounded_double_ended_queue #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  dq_pkg::deq_in_t            in_item,
  output logic                       done,
  output dq_pkg::deq_out_t           result,
  input  logic                       cfg_we,
  input  logic [dq_pkg::LIMIT_W-1:0] cfg_data
);
  import dq_pkg::*;

  dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  dq_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .result   (result)
  );

endmodule
